### rtl/core/wrp_pkg.sv
// Shared codes and field widths of the weighted random pick unit.
package wrp_pkg;

	// Field widths of the stream items.
	localparam int VALUE_W     = 32;
	localparam int WEIGHT_IN_W = 16;
	localparam int RAND_W      = 31;
	localparam int INDEX_OUT_W = 6;
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 40;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_ADD   = 2'd1;
	localparam logic [1:0] MODE_DRAW  = 2'd2;

	// Status codes carried in the output tuser.
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_DRAWN = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;
	localparam logic [1:0] STATUS_FULL  = 2'd3;

endpackage

### rtl/core/weighted_random_pick_unit.sv
// Weighted random pick unit: roulette-wheel selection over a stored table.
// Latency: clear, add and a draw on an empty table give their result one cycle after the transfer.
// A draw runs 31 steps of the bit-serial remainder unit,
// then one read of the entry memory per entry until the bound is found.
// One item is worked on at a time; the next is taken once the output register is free or drains.
// Reset empties the table and zeroes the total at once; the entry memory needs no clearing.
module weighted_random_pick_unit
	import wrp_pkg::*;
#(
	parameter int MAX_ENTRIES = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// new_value[31:0], weight[47:32], random_word[78:48], zero[79]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// drawn_value[31:0], drawn_index[37:32], zero[39:38]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [1:0]            m_tuser
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int TOT_W = WEIGHT_BITS + $clog2(MAX_ENTRIES);
	localparam int ENT_W = VALUE_W + TOT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       count_q;
	logic [TOT_W-1:0]       total_q;
	logic [TOT_W-1:0]       r_q;
	logic [CNT_W-1:0]       scan_addr_q;
	logic                   rd_pend_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [1:0]             fin_status_q;
	logic [VALUE_W-1:0]     fin_value_q;
	logic [IDX_W-1:0]       fin_index_q;
	logic                   out_valid_q;
	logic [1:0]             out_status_q;
	logic [VALUE_W-1:0]     out_value_q;
	logic [INDEX_OUT_W-1:0] out_index_q;

	logic [1:0]                   in_mode;
	logic [VALUE_W-1:0]           in_value;
	logic [WEIGHT_IN_W-1:0]       in_weight;
	logic [RAND_W-1:0]            in_rand;
	logic [WEIGHT_BITS+WEIGHT_IN_W-1:0] weight_ext;
	logic [WEIGHT_BITS-1:0]       weight_eff;
	logic [TOT_W-1:0]             total_next;
	logic                         out_free;
	logic                         accept;
	logic                         table_full;
	logic                         draw_go;
	logic                         imm_load;
	logic [1:0]                   imm_status;
	logic                         ram_we;
	logic [IDX_W-1:0]             ram_raddr;
	logic [ENT_W-1:0]             ram_rdata;
	logic [TOT_W-1:0]             rd_bound;
	logic                         hit;
	logic                         div_done;
	logic [TOT_W-1:0]             div_rem;
	logic [IDX_W+INDEX_OUT_W-1:0] index_ext;

	// Unpack the input item and mask the weight to its configured width.
	always_comb begin
		in_mode    = s_tuser;
		in_value   = s_tdata[31:0];
		in_weight  = s_tdata[47:32];
		in_rand    = s_tdata[78:48];
		weight_ext = {{WEIGHT_BITS{1'b0}}, in_weight};
		weight_eff = weight_ext[WEIGHT_BITS-1:0];
		total_next = total_q + TOT_W'(weight_eff);
		table_full = (count_q >= CNT_W'(MAX_ENTRIES));
	end

	// Handshake and decode of items that finish in the accepting cycle.
	always_comb begin
		out_free   = !out_valid_q || m_tready;
		s_tready   = (state_q == S_IDLE) && out_free;
		accept     = s_tvalid && s_tready;
		draw_go    = 1'b0;
		ram_we     = 1'b0;
		imm_status = STATUS_DONE;
		case (in_mode)
			MODE_ADD: begin
				if (weight_eff != '0) begin
					if (table_full) begin
						imm_status = STATUS_FULL;
					end else begin
						ram_we = accept;
					end
				end
			end
			MODE_DRAW: begin
				if (total_q == '0 || count_q == '0) begin
					imm_status = STATUS_EMPTY;
				end else begin
					draw_go = accept;
				end
			end
			default: begin
				imm_status = STATUS_DONE;
			end
		endcase
		imm_load = accept && !draw_go;
	end

	// Entry memory: stored value in the low bits, cumulative bound above it.
	wrp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({total_next, in_value}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Remainder of the random word by the running total.
	wrp_mod #(
		.TOT_W(TOT_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (draw_go),
		.dividend (in_rand),
		.divisor  (total_q),
		.done     (div_done),
		.remainder(div_rem)
	);

	// Scan compare on the entry read in the previous cycle.
	always_comb begin
		ram_raddr = scan_addr_q[IDX_W-1:0];
		rd_bound  = ram_rdata[ENT_W-1:VALUE_W];
		hit       = rd_pend_s1 && (r_q < rd_bound);
	end

	// Table bookkeeping and the draw sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			scan_addr_q <= '0;
			rd_pend_s1  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && in_mode == MODE_CLEAR) begin
						count_q <= '0;
						total_q <= '0;
					end
					if (ram_we) begin
						count_q <= count_q + 1'b1;
						total_q <= total_next;
					end
					if (draw_go) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						scan_addr_q <= '0;
						rd_pend_s1  <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						rd_pend_s1 <= 1'b0;
						state_q    <= S_FIN;
					end else if (scan_addr_q < count_q) begin
						rd_pend_s1  <= 1'b1;
						scan_addr_q <= scan_addr_q + 1'b1;
					end else begin
						rd_pend_s1 <= 1'b0;
						if (!rd_pend_s1) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Scan payload: remainder, index in flight and the pending result.
	always_ff @(posedge clk) begin
		if (div_done) begin
			r_q          <= div_rem;
			fin_status_q <= STATUS_EMPTY;
			fin_value_q  <= '0;
			fin_index_q  <= '0;
		end
		if (state_q == S_SCAN) begin
			rd_idx_s1 <= scan_addr_q[IDX_W-1:0];
			if (hit) begin
				fin_status_q <= STATUS_DRAWN;
				fin_value_q  <= ram_rdata[VALUE_W-1:0];
				fin_index_q  <= rd_idx_s1;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (imm_load || (state_q == S_FIN && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign index_ext = {{INDEX_OUT_W{1'b0}}, fin_index_q};

	// Output register payload.
	always_ff @(posedge clk) begin
		if (imm_load) begin
			out_status_q <= imm_status;
			out_value_q  <= '0;
			out_index_q  <= '0;
		end else if (state_q == S_FIN && out_free) begin
			out_status_q <= fin_status_q;
			out_value_q  <= fin_value_q;
			out_index_q  <= index_ext[INDEX_OUT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b00, out_index_q, out_value_q};

	// The fill count never passes the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table depth");

	// An empty table always carries a zero total.
	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (total_q == '0))
		else $error("empty table with nonzero total");

	// The remainder under scan lies below the total.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (r_q < total_q))
		else $error("remainder not below total");

	// Every entry read during the scan was written.
	a_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && rd_pend_s1) |-> (CNT_W'(rd_idx_s1) < count_q))
		else $error("scan read beyond filled entries");

	// The remainder unit finishes only while a draw waits on it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("remainder done outside a draw");

endmodule

### rtl/core/wrp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module wrp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/wrp_mod.sv
// Bit-serial remainder unit: reduces the random word modulo the running total.
module wrp_mod
	import wrp_pkg::*;
#(
	parameter int TOT_W = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAND_W-1:0] dividend,
	input  logic [TOT_W-1:0]  divisor,
	output logic              done,
	output logic [TOT_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(RAND_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAND_W-1:0] dvd_q;
	logic [TOT_W-1:0]  rem_q;
	logic [TOT_W-1:0]  dsr_q;
	logic [TOT_W:0]    shifted;
	logic [TOT_W:0]    diff;

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	always_comb begin
		shifted = {rem_q, dvd_q[RAND_W-1]};
		diff    = shifted - {1'b0, dsr_q};
	end

	// Control: count the steps and flag the cycle after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RAND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and the remaining dividend bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RAND_W-2:0], 1'b0};
			if (shifted >= {1'b0, dsr_q}) begin
				rem_q <= diff[TOT_W-1:0];
			end else begin
				rem_q <= shifted[TOT_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the weighted random pick unit.
module tb_top;
	import wrp_pkg::*;

	localparam int MAX_ENTRIES = 64;
	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE_CYCLES = 150;
	localparam int ITEM_BUDGET = 1300;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
		logic [5:0]  index;
	} pick_result_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] value;
		logic [15:0] weight;
		logic [30:0] rnd;
		logic        typed;
		logic [1:0]  status;
		logic [31:0] dvalue;
		logic [5:0]  dindex;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	// Local copy of the pick table.
	logic [31:0] tbl_value [MAX_ENTRIES];
	int unsigned tbl_bound [MAX_ENTRIES];
	int          tbl_count;
	int unsigned tbl_total;

	pick_result_t pending_picks[$];

	int mismatch_count;
	int items_sent;
	int results_seen;
	int drawn_count;
	int empty_count;
	int full_count;
	int top_index;
	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles;

	// Directed rows: extremes, every mode and the special cases.
	dir_row_t directed_rows [18] = '{
		'{MODE_DRAW,   32'h0,        16'h0,    31'h7FFFFFFF, 1'b1, STATUS_EMPTY, 32'h0, 6'd0},
		'{MODE_ADD,    32'h12345678, 16'h0,    31'h0,        1'b1, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_DRAW,   32'h0,        16'h0,    31'd5,        1'b1, STATUS_EMPTY, 32'h0, 6'd0},
		'{MODE_ADD,    32'h80000000, 16'h1,    31'h0,        1'b1, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_DRAW,   32'h0,        16'h0,    31'h0,        1'b1, STATUS_DRAWN,
			32'h80000000, 6'd0},
		'{MODE_DRAW,   32'h0,        16'h0,    31'h7FFFFFFF, 1'b1, STATUS_DRAWN,
			32'h80000000, 6'd0},
		'{MODE_ADD,    32'h7FFFFFFF, 16'hFFFF, 31'h0,        1'b1, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_DRAW,   32'h0,        16'h0,    31'd1,        1'b1, STATUS_DRAWN,
			32'h7FFFFFFF, 6'd1},
		'{MODE_DRAW,   32'h0,        16'h0,    31'h7FFFFFFF, 1'b0, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_DRAW,   32'h0,        16'h0,    31'd65536,    1'b0, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_UNUSED, 32'hFFFFFFFF, 16'hFFFF, 31'h7FFFFFFF, 1'b1, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_ADD,    32'hFFFFFFFF, 16'h8000, 31'h0,        1'b1, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_DRAW,   32'h0,        16'h0,    31'h5A5A5A5A, 1'b0, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_CLEAR,  32'hFFFFFFFF, 16'hFFFF, 31'h7FFFFFFF, 1'b1, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_DRAW,   32'h0,        16'h0,    31'h0,        1'b1, STATUS_EMPTY, 32'h0, 6'd0},
		'{MODE_ADD,    32'h0,        16'h2,    31'h0,        1'b1, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_DRAW,   32'h0,        16'h0,    31'h55555555, 1'b0, STATUS_DONE,  32'h0, 6'd0},
		'{MODE_DRAW,   32'h0,        16'h0,    31'h2AAAAAAA, 1'b0, STATUS_DONE,  32'h0, 6'd0}
	};

	weighted_random_pick_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the result of one accepted item and updates the local table.
	function automatic pick_result_t predict_pick(logic [1:0] mode, logic [31:0] value,
			logic [15:0] weight, logic [30:0] rnd);
		pick_result_t res;
		int unsigned  rem;
		bit           found;
		int           k;
		res.status = STATUS_DONE;
		res.value  = 32'h0;
		res.index  = 6'd0;
		found      = 1'b0;
		case (mode)
			MODE_CLEAR: begin
				tbl_count = 0;
				tbl_total = 0;
			end
			MODE_ADD: begin
				// A zero weight is ignored before the full check.
				if (weight != 16'h0) begin
					if (tbl_count >= MAX_ENTRIES) begin
						res.status = STATUS_FULL;
					end else begin
						tbl_total += 32'(weight);
						tbl_value[tbl_count] = value;
						tbl_bound[tbl_count] = tbl_total;
						tbl_count++;
					end
				end
			end
			MODE_DRAW: begin
				res.status = STATUS_EMPTY;
				if (tbl_total != 0 && tbl_count != 0) begin
					rem = {1'b0, rnd} % tbl_total;
					for (k = 0; k < tbl_count; k++) begin
						if (!found && rem < tbl_bound[k]) begin
							found      = 1'b1;
							res.status = STATUS_DRAWN;
							res.value  = tbl_value[k];
							res.index  = k[5:0];
						end
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH at result %0d: %s got %0h expected %0h",
			results_seen, what, got, want);
		mismatch_count++;
	endtask

	// Drives one item, starting at a falling edge, and returns at the falling edge after
	// its transfer. The expectation is queued at the edge where the transfer happens.
	task automatic send_item(logic [1:0] mode, logic [31:0] value, logic [15:0] weight,
			logic [30:0] rnd, bit typed, pick_result_t typed_res);
		pick_result_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, rnd, weight, value};
		s_tuser  <= mode;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = predict_pick(mode, value, weight, rnd);
		pending_picks.insert(pending_picks.size(), typed ? typed_res : res);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_plain(logic [1:0] mode, logic [31:0] value, logic [15:0] weight,
			logic [30:0] rnd);
		send_item(mode, value, weight, rnd, 1'b0, '0);
	endtask

	// Holds the sender off until every queued result has come back.
	task automatic wait_for_drain();
		while (pending_picks.size() != 0) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
	endtask

	function automatic logic [15:0] pick_weight();
		int c;
		c = $urandom_range(0, 99);
		if (c < 8) return 16'h0;
		if (c < 16) return 16'($urandom_range(1, 3));
		if (c < 24) return 16'hFFFF;
		return 16'($urandom_range(1, 65535));
	endfunction

	// One well-formed set: clear, fill the table, then draw from it, with some noise mixed in.
	task automatic run_table_set();
		int          kind;
		int          n_adds;
		int          n_draws;
		int          k;
		longint      aim;
		logic [30:0] rnd;
		kind = $urandom_range(0, 99);
		send_plain(MODE_CLEAR, $urandom, 16'($urandom), 31'($urandom));
		if (kind < 4) n_adds = 0;
		else if (kind < 80) n_adds = $urandom_range(1, 12);
		else if (kind < 90) n_adds = $urandom_range(13, 63);
		else n_adds = $urandom_range(64, 72);
		for (k = 0; k < n_adds; k++) begin
			if ($urandom_range(0, 99) < 5) begin
				send_plain(2'($urandom_range(0, 3)), $urandom, 16'($urandom), 31'($urandom));
			end
			send_plain(MODE_ADD, $urandom, pick_weight(), 31'($urandom));
		end
		n_draws = (n_adds >= 64) ? $urandom_range(12, 20) : $urandom_range(2, 10);
		for (k = 0; k < n_draws; k++) begin
			// Some draws land on the last bound to reach deep table positions.
			if ($urandom_range(0, 99) < 25 && tbl_total != 0) begin
				aim = longint'(tbl_total) * $urandom_range(0, 500) + tbl_total - 1;
				rnd = aim[30:0];
			end else begin
				rnd = 31'($urandom);
			end
			send_plain(MODE_DRAW, $urandom, 16'($urandom), rnd);
		end
	endtask

	// Stimulus: reset, directed rows, then random table sets over three idling phases.
	initial begin
		pick_result_t typed_res;
		int           r;
		int           phase;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = MODE_CLEAR;
		m_tready       = 1'b0;
		mismatch_count = 0;
		items_sent     = 0;
		results_seen   = 0;
		drawn_count    = 0;
		empty_count    = 0;
		full_count     = 0;
		top_index      = 0;
		tbl_count      = 0;
		tbl_total      = 0;
		send_idle_pct  = 12;
		recv_idle_pct  = 88;
		phase          = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (r = 0; r < $size(directed_rows); r++) begin
			typed_res.status = directed_rows[r].status;
			typed_res.value  = directed_rows[r].dvalue;
			typed_res.index  = directed_rows[r].dindex;
			send_item(directed_rows[r].mode, directed_rows[r].value, directed_rows[r].weight,
				directed_rows[r].rnd, directed_rows[r].typed, typed_res);
		end

		while (items_sent < ITEM_BUDGET) begin
			if (phase == 0 && items_sent >= ITEM_BUDGET / 3) begin
				wait_for_drain();
				phase         = 1;
				send_idle_pct = 88;
				recv_idle_pct = 12;
			end else if (phase == 1 && items_sent >= 2 * ITEM_BUDGET / 3) begin
				wait_for_drain();
				phase         = 2;
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			run_table_set();
		end

		// Let the last results arrive, then allow for a late stray result.
		wait_for_drain();
		s_tvalid <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_picks.size() != 0) begin
			report_mismatch("results still outstanding", pending_picks.size(), 0);
		end
		$display("Ran %0d items through clear, add, draw and unused modes; %0d results checked.",
			items_sent, results_seen);
		$display("%0d draws picked an entry (deepest index %0d), %0d drew nothing, %0d adds full.",
			drawn_count, top_index, empty_count, full_count);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Checks each result transfer against the oldest expectation.
	always @(posedge clk) begin
		pick_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_picks.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata[31:0], 0);
			end else begin
				want = pending_picks.pop_front();
				if (m_tuser !== want.status) begin
					report_mismatch("status", 32'(m_tuser), 32'(want.status));
				end
				if (m_tdata[31:0] !== want.value) begin
					report_mismatch("drawn_value", m_tdata[31:0], want.value);
				end
				if (m_tdata[37:32] !== want.index) begin
					report_mismatch("drawn_index", 32'(m_tdata[37:32]), 32'(want.index));
				end
				case (want.status)
					STATUS_DRAWN: begin
						drawn_count++;
						if (int'(want.index) > top_index) top_index = int'(want.index);
					end
					STATUS_EMPTY: empty_count++;
					STATUS_FULL: full_count++;
					default: ;
				endcase
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule
